// ===== hdl/speed_slew_limiter_with_kick_assert.svh =====
// ----------------------------------------------------------------------------
// speed_slew_limiter_with_kick_assert.svh
// assertion macros for the speed slew limiter
// ----------------------------------------------------------------------------
`ifndef SPEED_SLEW_LIMITER_WITH_KICK_ASSERT_SVH
`define SPEED_SLEW_LIMITER_WITH_KICK_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SSLK_ASSERT_NOW(label, clk_i, rst_ni, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
        else $error("sslk assertion failed");

// antecedent implies consequent in the next cycle
`define SSLK_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
        else $error("sslk assertion failed");

`endif

// ===== hdl/sslk_pkg.sv =====
// ----------------------------------------------------------------------------
// sslk_pkg
// types and constants of the speed slew limiter
// ----------------------------------------------------------------------------
package sslk_pkg;

    localparam int SPEED_W = 16;
    localparam int DT_W    = 16;
    localparam int KICK_W  = 15;
    localparam int RATE_W  = 16;
    localparam int STEP_W  = 13;
    localparam int CIDX_W  = 2;

    // clamped time step fits in step width
    localparam logic [DT_W-1:0]   DT_LIMIT   = 16'd6553;
    localparam logic [STEP_W-1:0] DT_DEFAULT = 13'd328;

    localparam logic signed [SPEED_W:0] TINY_MAX = 17'sd4;

    localparam logic [KICK_W-1:0] KICK_RESET  = 15'd410;
    localparam logic [RATE_W-1:0] ACCEL_RESET = 16'd2458;
    localparam logic [RATE_W-1:0] DECEL_RESET = 16'd8192;

    typedef enum logic [CIDX_W-1:0] {
        CFG_KICK  = 2'd0,
        CFG_ACCEL = 2'd1,
        CFG_DECEL = 2'd2
    } cfg_idx_t;

endpackage

// ===== hdl/speed_slew_limiter_with_kick.sv =====
// ----------------------------------------------------------------------------
// speed_slew_limiter_with_kick
// slew rate limiter for a commanded speed with a start kick from rest
// ----------------------------------------------------------------------------
// usage
//   input channel: target_speed (signed q3.12) and time_step (q0.16 s),
//   request taken when in_valid is high and in_stall is low
//   output channel: command_speed (signed q3.12), request taken when
//   out_valid is high and out_stall is low; the delivered speed is also
//   the present speed that the next request works from
//   config channel: cfg_index / cfg_data, written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high, unknown indexes ignored
//   path: input register, then result register; a result is valid once the
//   input register moves it on, which a stalled result can hold off
//   throughput: one request per cycle unless stalled, set by the single pass
//   from input register to result register (multiply, compares, add)
//   reset: present speed is zero, registers take their reset values,
//   both registers are empty
//   stall: a stalled result holds; the input register takes one more
//   request; once it is full, in_stall follows out_stall
// ----------------------------------------------------------------------------
`include "speed_slew_limiter_with_kick_assert.svh"

module speed_slew_limiter_with_kick
    import sslk_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SPEED_W-1:0]  target_speed,
    input  logic        [DT_W-1:0]     time_step,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SPEED_W-1:0]  command_speed,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic        [CIDX_W-1:0]   cfg_index,
    input  logic        [RATE_W-1:0]   cfg_data
);

    logic [KICK_W-1:0] kick_reg;
    logic [RATE_W-1:0] accel_reg;
    logic [RATE_W-1:0] decel_reg;

    logic                      s1_valid_reg;
    logic signed [SPEED_W-1:0] s1_target_reg;
    logic [STEP_W-1:0]         s1_dt_reg;

    logic                      out_valid_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic signed [SPEED_W-1:0] speed_next;

    logic              out_free;
    logic              s1_free;
    logic              s1_move;
    logic              in_take;
    logic [STEP_W-1:0] dt_clamped;
    logic [RATE_W+STEP_W-1:0] lim_prod;
    logic [RATE_W+STEP_W-1:0] decay_prod;
    logic [STEP_W-1:0] lim_step;
    logic [STEP_W-1:0] decay_step;

    // flow control
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_free  = !s1_valid_reg || out_free;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_take  = in_valid && s1_free;

    assign in_stall      = !s1_free;
    assign out_valid     = out_valid_reg;
    assign command_speed = speed_reg;
    assign cfg_ready     = 1'b1;

    // long time step replaced by default
    assign dt_clamped = (time_step > DT_LIMIT) ? DT_DEFAULT : time_step[STEP_W-1:0];

    assign lim_prod   = accel_reg * s1_dt_reg;
    assign decay_prod = decel_reg * s1_dt_reg;
    assign lim_step   = lim_prod[RATE_W+STEP_W-1:RATE_W];
    assign decay_step = decay_prod[RATE_W+STEP_W-1:RATE_W];

    // state update
    always_comb
    begin
        logic signed [SPEED_W:0]   cur_x;
        logic signed [SPEED_W:0]   tgt_x;
        logic signed [SPEED_W:0]   kick_x;
        logic signed [SPEED_W:0]   lim_x;
        logic signed [SPEED_W:0]   dec_x;
        logic signed [SPEED_W:0]   dec_res;
        logic signed [SPEED_W:0]   delta;
        logic signed [SPEED_W+1:0] sum;
        logic signed [SPEED_W+1:0] tgt_w;
        logic signed [SPEED_W-1:0] nxt;
        logic                      cur_tiny;
        logic                      tgt_tiny;

        cur_x  = {speed_reg[SPEED_W-1], speed_reg};
        tgt_x  = {s1_target_reg[SPEED_W-1], s1_target_reg};
        kick_x = $signed({2'b00, kick_reg});
        lim_x  = $signed({{(SPEED_W+1-STEP_W){1'b0}}, lim_step});
        dec_x  = $signed({{(SPEED_W+1-STEP_W){1'b0}}, decay_step});
        tgt_w  = {tgt_x[SPEED_W], tgt_x};

        cur_tiny = (cur_x >= -TINY_MAX) && (cur_x <= TINY_MAX);
        tgt_tiny = (tgt_x >= -TINY_MAX) && (tgt_x <= TINY_MAX);

        if (cur_x > 0)
        begin
            dec_res = ((cur_x - dec_x) > 0) ? (cur_x - dec_x) : '0;
        end
        else
        begin
            dec_res = ((cur_x + dec_x) < 0) ? (cur_x + dec_x) : '0;
        end

        delta = tgt_x - cur_x;
        if (delta > lim_x)
        begin
            delta = lim_x;
        end
        if (delta < -lim_x)
        begin
            delta = -lim_x;
        end
        sum = {cur_x[SPEED_W], cur_x} + {delta[SPEED_W], delta};
        if (sum > 18'sd32767)
        begin
            nxt = 16'sh7fff;
        end
        else if (sum < -18'sd32768)
        begin
            nxt = 16'sh8000;
        end
        else
        begin
            nxt = sum[SPEED_W-1:0];
        end
        if ((delta > 0 && sum > tgt_w) || (delta < 0 && sum < tgt_w))
        begin
            nxt = s1_target_reg;
        end

        if (tgt_tiny)
        begin
            speed_next = cur_tiny ? '0 : dec_res[SPEED_W-1:0];
        end
        else if (cur_tiny)
        begin
            if ((tgt_x >= -kick_x) && (tgt_x <= kick_x))
            begin
                speed_next = s1_target_reg;
            end
            else if (tgt_x > 0)
            begin
                speed_next = kick_x[SPEED_W-1:0];
            end
            else
            begin
                speed_next = 16'(-kick_x);
            end
        end
        else
        begin
            speed_next = nxt;
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kick_reg  <= KICK_RESET;
            accel_reg <= ACCEL_RESET;
            decel_reg <= DECEL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KICK:  kick_reg  <= cfg_data[KICK_W-1:0];
                CFG_ACCEL: accel_reg <= cfg_data;
                CFG_DECEL: decel_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            speed_reg     <= '0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_move)
            begin
                speed_reg <= speed_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_target_reg <= target_speed;
            s1_dt_reg     <= dt_clamped;
        end
    end

    `SSLK_ASSERT_NOW(a_empty_no_stall, clk, rst_n, !s1_valid_reg, !in_stall)
    `SSLK_ASSERT_NEXT(a_move_gives_result, clk, rst_n, s1_move, out_valid_reg)
    `SSLK_ASSERT_NEXT(a_tiny_rest_zero, clk, rst_n,
        s1_move && (s1_target_reg == 16'sd0) && (speed_reg == 16'sd0), speed_reg == 16'sd0)
    `SSLK_ASSERT_NEXT(a_no_overshoot_up, clk, rst_n,
        s1_move && (s1_target_reg >= speed_reg) && ((s1_target_reg > TINY_MAX) || (s1_target_reg < -TINY_MAX)), speed_reg <= $past(s1_target_reg))
    `SSLK_ASSERT_NEXT(a_hold_when_idle, clk, rst_n, !s1_move, $stable(speed_reg))

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the speed slew limiter with start kick
// ----------------------------------------------------------------------------
// a request-level predictor keeps its own present speed and register copies and
// works out the commanded speed for every accepted request; results are
// checked in order against the queue of predicted speeds. directed requests
// cover rest, kick, motion, decay and time step clamping at reset and at
// extreme register values; random runs hold one target for a while so the
// speed reaches motion and decay, with random noise mixed in. both channels
// idle at random, and registers change only while the block is empty.
// ----------------------------------------------------------------------------
module testbench;
    import sslk_pkg::*;

    localparam int BLOCK_LATENCY = 2;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_LIMIT   = 20000;
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [SPEED_W-1:0] target_speed;
    logic        [DT_W-1:0]    time_step;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [SPEED_W-1:0] command_speed;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic        [CIDX_W-1:0]  cfg_index;
    logic        [RATE_W-1:0]  cfg_data;

    logic signed [SPEED_W-1:0] predicted_speeds[$];
    int                        speed_now;
    int                        kick_now;
    int                        accel_now;
    int                        decel_now;
    int                        failures;
    int                        cycles;
    int                        stall_left;
    bit                        calm;

    speed_slew_limiter_with_kick dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .target_speed  (target_speed),
        .time_step     (time_step),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .command_speed (command_speed),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL speed_slew_limiter_with_kick");
            $finish;
        end
    end

    function automatic int abs_of(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // next commanded speed, updates the predicted present speed
    function automatic logic signed [SPEED_W-1:0] slew_predict(
        input logic signed [SPEED_W-1:0] tgt,
        input logic        [DT_W-1:0]    dt_in
    );
        int t;
        int cur;
        int dt;
        int step;
        int delta;
        int nxt;
        t   = tgt;
        cur = speed_now;
        dt  = dt_in;
        if (dt > int'(DT_LIMIT))
            dt = int'(DT_DEFAULT);
        if (abs_of(t) <= int'(TINY_MAX))
        begin
            if (abs_of(cur) <= int'(TINY_MAX))
                cur = 0;
            else
            begin
                step = (decel_now * dt) >>> 16;
                if (cur > 0)
                    cur = (cur - step > 0) ? cur - step : 0;
                else
                    cur = (cur + step < 0) ? cur + step : 0;
            end
        end
        else if (abs_of(cur) <= int'(TINY_MAX))
        begin
            if (abs_of(t) <= kick_now)
                cur = t;
            else
                cur = (t > 0) ? kick_now : -kick_now;
        end
        else
        begin
            step  = (accel_now * dt) >>> 16;
            delta = t - cur;
            if (delta > step)
                delta = step;
            if (delta < -step)
                delta = -step;
            nxt = cur + delta;
            if (nxt > 32767)
                nxt = 32767;
            if (nxt < -32768)
                nxt = -32768;
            if ((delta > 0 && nxt > t) || (delta < 0 && nxt < t))
                nxt = t;
            cur = nxt;
        end
        speed_now = cur;
        return cur[SPEED_W-1:0];
    endfunction

    function automatic logic signed [SPEED_W-1:0] pick_target();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 15)
            v = 0;
        else if (r < 35)
            v = $urandom_range(0, 8) - 4;
        else if (r < 50)
        begin
            case ($urandom_range(0, 7))
                0: v = 32767;
                1: v = -32768;
                2: v = kick_now;
                3: v = -kick_now;
                4: v = kick_now + 1;
                5: v = -kick_now - 1;
                6: v = 5;
                default: v = -5;
            endcase
        end
        else
            v = $urandom_range(0, 65535);
        return v[SPEED_W-1:0];
    endfunction

    function automatic logic [DT_W-1:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 16'($urandom_range(0, int'(DT_LIMIT)));
        if (r < 65)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return DT_LIMIT;
                2: return DT_LIMIT + 16'd1;
                default: return '1;
            endcase
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall = 1'b0;
            if (!calm && $urandom_range(0, 2) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin : check_results
        logic signed [SPEED_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_speeds.size() == 0)
            begin
                $error("command_speed: expected none, actual %0d", command_speed);
                failures++;
            end
            else
            begin
                want = predicted_speeds.pop_front();
                if (command_speed !== want)
                begin
                    $error("command_speed: expected %0d, actual %0d", want, command_speed);
                    failures++;
                end
            end
        end
    end

    task automatic send_request(
        input logic signed [SPEED_W-1:0] tgt,
        input logic        [DT_W-1:0]    dt
    );
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        target_speed = tgt;
        time_step    = dt;
        do
            @(posedge clk);
        while (in_stall);
        predicted_speeds.push_back(slew_predict(tgt, dt));
    endtask

    // hold off until every predicted speed has come back and the pipe is empty
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (predicted_speeds.size() != 0)
            @(negedge clk);
        repeat (BLOCK_LATENCY + 2) @(negedge clk);
    endtask

    task automatic write_register(
        input logic [CIDX_W-1:0] idx,
        input logic [RATE_W-1:0] data
    );
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_KICK:  kick_now  = data[KICK_W-1:0];
            CFG_ACCEL: accel_now = data;
            CFG_DECEL: decel_now = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic program_rates(
        input logic [RATE_W-1:0] kick,
        input logic [RATE_W-1:0] accel,
        input logic [RATE_W-1:0] decel
    );
        settle();
        write_register(CFG_KICK, kick);
        write_register(CFG_ACCEL, accel);
        write_register(CFG_DECEL, decel);
    endtask

    task automatic test_start_and_motion();
        send_request(16'sd0, 16'd100);
        send_request(16'sd4, 16'd100);
        send_request(-16'sd4, 16'd100);
        send_request(16'sd5, 16'd100);
        send_request(16'sd0, 16'd0);
        send_request(16'sd0, 16'hFFFF);
        send_request(16'sh7FFF, 16'd100);
        send_request(16'sh7FFF, DT_LIMIT);
        send_request(16'sh7FFF, DT_LIMIT + 16'd1);
        send_request(-16'sh8000, DT_LIMIT);
        send_request(16'sd0, DT_LIMIT);
        send_request(-16'sh8000, 16'd10);
        send_request(-16'sd100, DT_LIMIT);
        send_request(-16'sd100, DT_LIMIT);
        send_request(16'sd3, DT_LIMIT);
    endtask

    task automatic test_register_limits();
        program_rates(16'd0, 16'hFFFF, 16'hFFFF);
        write_register(CFG_UNUSED, 16'h1234);
        send_request(16'sd1234, 16'd50);
        send_request(16'sd5, 16'd50);
        program_rates(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(-16'sh8000, 16'd50);
        send_request(16'sd0, 16'd50);
        send_request(16'sh7FFF, 16'd50);
        send_request(-16'sh8000, DT_LIMIT);
        send_request(16'sd0, DT_LIMIT);
        program_rates(16'd410, 16'd0, 16'd0);
        send_request(16'sd2000, DT_LIMIT);
        send_request(-16'sd2000, DT_LIMIT);
    endtask

    // runs of one held target with random time steps, some noise between
    task automatic run_sequences(input int count);
        logic signed [SPEED_W-1:0] goal;
        int left;
        int i;
        left = 0;
        for (i = 0; i < count; i++)
        begin
            if (left == 0)
            begin
                goal = pick_target();
                left = $urandom_range(1, 24);
            end
            left--;
            if ($urandom_range(0, 9) == 0)
                send_request(pick_target(), pick_step());
            else
                send_request(goal, pick_step());
        end
    endtask

    task automatic test_random_sequences();
        int phase;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: program_rates(KICK_RESET, ACCEL_RESET, DECEL_RESET);
                1: program_rates(16'd0, 16'd1, 16'd1);
                2: program_rates(16'hFFFF, 16'hFFFF, 16'd0);
                default: program_rates(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            calm = (phase == 1);
            run_sequences(200);
            settle();
            run_sequences(200);
            calm = 1'b0;
        end
    endtask

    initial
    begin : main
        int n;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        target_speed = '0;
        time_step    = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        failures     = 0;
        cycles       = 0;
        stall_left   = 0;
        calm         = 1'b0;
        speed_now    = 0;
        kick_now     = KICK_RESET;
        accel_now    = ACCEL_RESET;
        decel_now    = DECEL_RESET;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_start_and_motion();
        test_register_limits();
        test_random_sequences();

        @(negedge clk);
        in_valid = 1'b0;
        for (n = 0; n < DRAIN_LIMIT && predicted_speeds.size() != 0; n++)
            @(posedge clk);
        if (predicted_speeds.size() != 0)
        begin
            $error("command_speed: %0d results never arrived", predicted_speeds.size());
            failures++;
        end
        repeat (BLOCK_LATENCY + 5) @(posedge clk);
        if (failures == 0)
            $display("PASS speed_slew_limiter_with_kick");
        else
            $display("FAIL speed_slew_limiter_with_kick");
        $finish;
    end

endmodule

// ===== speed_slew_limiter_with_kick.f =====
+incdir+hdl
hdl/sslk_pkg.sv
hdl/speed_slew_limiter_with_kick.sv
tb/testbench.sv
